### design/bmf_pkg.sv
// Shared types and constants of the box mean filter.
`timescale 1ns / 1ps
`default_nettype none
package bmf_pkg;

	// APB address width and register word indexes
	localparam int unsigned PADDR_W = 4;
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_KH     = 2'd2;
	localparam logic [1:0] REG_KW     = 2'd3;

	// Register reset values
	localparam logic [10:0] RST_WIDTH  = 11'd1024;
	localparam logic [12:0] RST_HEIGHT = 13'd1024;
	localparam logic [2:0]  RST_KERNEL = 3'd3;

	// Input command codes
	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	// Control sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LATCH,
		ST_PROD,
		ST_DECIDE,
		ST_SWEEP,
		ST_ACC,
		ST_DIV,
		ST_OUT
	} state_t;

	// Divider control
	typedef struct packed {
		logic start;
		logic done;
	} div_ctl_t;

endpackage
`default_nettype wire

### design/bmf_store.sv
// Line store: ring of recent pixels in a synchronous single-port-write RAM.
`timescale 1ns / 1ps
`default_nettype none
module bmf_store #(
	parameter int unsigned AW = 13
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [7:0]    wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic [7:0]         rd_data
);

	logic [7:0] mem [2**AW];

	// Write one pixel
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

### design/bmf_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module bmf_div #(
	parameter int unsigned DW = 16,
	parameter int unsigned VW = 7
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] dividend,
	input  wire logic [VW-1:0] divisor,
	output logic               done,
	output logic [DW-1:0]      quotient
);

	localparam int unsigned NW = $clog2(DW + 1);

	logic [VW-1:0] rem_q;
	logic [DW-1:0] quo_q;
	logic [VW-1:0] div_q;
	logic [NW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [VW:0]   trial;
	logic          fits;

	// Trial subtract
	always_comb begin
		trial = {rem_q, quo_q[DW-1]};
		fits  = trial >= {1'b0, div_q};
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == NW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift in one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? VW'(trial - {1'b0, div_q}) : trial[VW-1:0];
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

### design/box_mean_filter_2d_top.sv
// Top level: streaming centered box-mean filter with APB configuration.
//
// Usage: pixels enter in raster order on the in channel (cmd = 0) and rounded
// window means leave on the out channel, one word per output position; the
// last word of a frame carries frame_last. Output k appears on input item
// k + (kh/2)*width + kw/2; after the frame, flush items (cmd = 1) push out
// the rest, one each. Sizes are latched from the registers at the first
// pixel of a frame.
// Timing: one item at a time. For an item that yields a result, the window is
// summed by reading the line store one tap per cycle, then the mean comes
// from a bit-serial divider (DW bits wide, 16 by default). A first pixel of a
// frame also passes the latch and product states to latch sizes; an item
// that yields no result skips the sweep and the divider.
// Reset: registers return to 1024 x 1024, kernel 3 x 3; counters clear.
// The line store needs no clear: every tap read was written in the frame.
// Stall: the result sits in an output register; the next item is accepted
// meanwhile and waits for that register only if it reaches its own result first.
`timescale 1ns / 1ps
`default_nettype none
module box_mean_filter_2d_top #(
	parameter int unsigned MAX_WIDTH  = 1024,
	parameter int unsigned MAX_KERNEL = 7
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [bmf_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        cmd,
	input  wire logic [7:0]                  pixel_in,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [7:0]                       pixel_out,
	output logic                             frame_last
);

	localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);
	localparam int unsigned CW   = $clog2(MAX_WIDTH * 8191 + 1) + 1;
	localparam int unsigned HALF = MAX_KERNEL / 2;
	localparam int unsigned AW   = $clog2(2 * (HALF * MAX_WIDTH + HALF) + 1);
	localparam int unsigned SW   = $clog2(MAX_KERNEL * MAX_KERNEL * 255 + 1);
	localparam int unsigned DW   = SW + 2;
	localparam int unsigned VW   = $clog2(2 * MAX_KERNEL * MAX_KERNEL + 1);
	localparam logic [3:0]  KMAX = 4'(MAX_KERNEL);
	localparam logic [2:0]  KCAP = 3'((MAX_KERNEL - 1) | 1);

	// Configuration registers
	logic [10:0] cfg_w_q;
	logic [12:0] cfg_h_q;
	logic [2:0]  cfg_kh_q;
	logic [2:0]  cfg_kw_q;

	// Frame sizes
	logic [WW-1:0] fr_w_q;
	logic [12:0]   fr_h_q;
	logic [1:0]    hh_q;
	logic [1:0]    hw_q;
	logic [CW-1:0] total_q;
	logic [CW-1:0] hhw_q;
	logic [VW-1:0] area_q;

	// Position counters
	logic [CW-1:0] in_cnt_q;
	logic [CW-1:0] out_cnt_q;
	logic [12:0]   out_row_q;
	logic [WW-1:0] out_col_q;

	// Item and sweep state
	bmf_pkg::state_t state_q, state_d;
	logic          cmd_q;
	logic [7:0]    pix_q;
	logic [2:0]    ti_q;
	logic [2:0]    tj_q;
	logic [AW-1:0] row_base_q;
	logic          tap_ok_s1;
	logic [SW-1:0] sum_q;
	logic          out_valid_q;
	logic [7:0]    pixel_out_q;
	logic          frame_last_q;

	// Helpers
	logic            start_frame;
	logic            in_lt;
	logic [CW-1:0]   in_next;
	logic [CW-1:0]   lat;
	logic            emit;
	logic [13:0]     rr;
	logic [WW:0]     cc;
	logic            tap_ok;
	logic            row_end;
	logic            tap_last;
	logic [AW-1:0]   tap_addr;
	logic            out_free;
	logic            frame_end;
	logic [2:0]      kh_eff;
	logic [2:0]      kw_eff;
	logic [WW-1:0]   w_eff;
	logic [12:0]     h_eff;
	logic            wr_en;
	logic [7:0]      rd_data;
	logic [SW-1:0]   sum_all;
	logic [DW-1:0]   quotient;
	logic [DW-1:0]   dividend;
	bmf_pkg::div_ctl_t div_ctl;

	// APB register file
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q  <= bmf_pkg::RST_WIDTH;
			cfg_h_q  <= bmf_pkg::RST_HEIGHT;
			cfg_kh_q <= bmf_pkg::RST_KERNEL;
			cfg_kw_q <= bmf_pkg::RST_KERNEL;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				bmf_pkg::REG_WIDTH:  cfg_w_q  <= pwdata[10:0];
				bmf_pkg::REG_HEIGHT: cfg_h_q  <= pwdata[12:0];
				bmf_pkg::REG_KH:     cfg_kh_q <= pwdata[2:0];
				bmf_pkg::REG_KW:     cfg_kw_q <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			bmf_pkg::REG_WIDTH:  prdata = {21'd0, cfg_w_q};
			bmf_pkg::REG_HEIGHT: prdata = {19'd0, cfg_h_q};
			bmf_pkg::REG_KH:     prdata = {29'd0, cfg_kh_q};
			bmf_pkg::REG_KW:     prdata = {29'd0, cfg_kw_q};
			default:             prdata = '0;
		endcase
	end

	// Effective sizes from the registers
	always_comb begin
		kh_eff = cfg_kh_q | 3'd1;
		if ({1'b0, kh_eff} > KMAX) kh_eff = KCAP;
		kw_eff = cfg_kw_q | 3'd1;
		if ({1'b0, kw_eff} > KMAX) kw_eff = KCAP;
		if (cfg_w_q == 11'd0) begin
			w_eff = WW'(1);
		end else if (32'(cfg_w_q) > 32'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(cfg_w_q);
		end
		h_eff = (cfg_h_q == 13'd0) ? 13'd1 : cfg_h_q;
	end

	// Item decisions
	always_comb begin
		start_frame = (in_cnt_q == '0) && (out_cnt_q == '0);
		in_lt       = in_cnt_q < total_q;
		in_next     = in_cnt_q + 1'b1;
		lat         = hhw_q + CW'(hw_q);
		if (in_lt) begin
			emit = (cmd_q == bmf_pkg::CMD_PIXEL) && (out_cnt_q + lat < in_next);
		end else begin
			emit = (cmd_q == bmf_pkg::CMD_FLUSH) && (out_cnt_q < total_q);
		end
		wr_en = (state_q == bmf_pkg::ST_DECIDE) && in_lt && (cmd_q == bmf_pkg::CMD_PIXEL);
	end

	// Window tap address and frame bounds
	always_comb begin
		rr       = {1'b0, out_row_q} + 14'(ti_q);
		cc       = {1'b0, out_col_q} + (WW+1)'(tj_q);
		tap_ok   = (rr >= 14'(hh_q)) && (rr < 14'(fr_h_q) + 14'(hh_q))
			&& (cc >= (WW+1)'(hw_q)) && (cc < {1'b0, fr_w_q} + (WW+1)'(hw_q));
		tap_addr = row_base_q + AW'(tj_q) - AW'(hw_q);
		row_end  = tj_q == {hw_q, 1'b0};
		tap_last = row_end && (ti_q == {hh_q, 1'b0});
		out_free = !out_valid_q || out_ready;
		frame_end = out_cnt_q + 1'b1 >= total_q;
		// fold in the last tap, which lands in the cycle the divider starts
		sum_all  = sum_q + (tap_ok_s1 ? SW'(rd_data) : SW'(0));
		dividend = DW'({sum_all, 1'b0}) + DW'(area_q);
	end

	// Next state
	always_comb begin
		state_d       = state_q;
		div_ctl.start = 1'b0;
		unique case (state_q)
			bmf_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (!start_frame) state_d = bmf_pkg::ST_DECIDE;
					else if (cmd == bmf_pkg::CMD_PIXEL) state_d = bmf_pkg::ST_LATCH;
				end
			end
			bmf_pkg::ST_LATCH: state_d = bmf_pkg::ST_PROD;
			bmf_pkg::ST_PROD:  state_d = bmf_pkg::ST_DECIDE;
			bmf_pkg::ST_DECIDE: state_d = emit ? bmf_pkg::ST_SWEEP : bmf_pkg::ST_IDLE;
			bmf_pkg::ST_SWEEP: if (tap_last) state_d = bmf_pkg::ST_ACC;
			bmf_pkg::ST_ACC: begin
				div_ctl.start = 1'b1;
				state_d       = bmf_pkg::ST_DIV;
			end
			bmf_pkg::ST_DIV: if (div_ctl.done) state_d = bmf_pkg::ST_OUT;
			bmf_pkg::ST_OUT: if (out_free) state_d = bmf_pkg::ST_IDLE;
			default: state_d = bmf_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bmf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = state_q == bmf_pkg::ST_IDLE;

	// Capture item, latch frame sizes
	always_ff @(posedge clk) begin
		if (state_q == bmf_pkg::ST_IDLE && in_valid) begin
			cmd_q <= cmd;
			pix_q <= pixel_in;
		end
		if (state_q == bmf_pkg::ST_LATCH) begin
			fr_w_q <= w_eff;
			fr_h_q <= h_eff;
			hh_q   <= kh_eff[2:1];
			hw_q   <= kw_eff[2:1];
		end
		if (state_q == bmf_pkg::ST_PROD) begin
			total_q <= CW'(fr_w_q) * CW'(fr_h_q);
			hhw_q   <= CW'(fr_w_q) * CW'(hh_q);
			area_q  <= VW'({hh_q, 1'b1}) * VW'({hw_q, 1'b1});
		end
	end

	// Sizes before the first frame
	// (the counters start at zero, so a frame always latches before use)

	// Position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cnt_q  <= '0;
			out_cnt_q <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else begin
			if (wr_en) in_cnt_q <= in_next;
			if (state_q == bmf_pkg::ST_OUT && out_free) begin
				if (frame_end) begin
					in_cnt_q  <= '0;
					out_cnt_q <= '0;
					out_row_q <= '0;
					out_col_q <= '0;
				end else begin
					out_cnt_q <= out_cnt_q + 1'b1;
					if (out_col_q + 1'b1 >= fr_w_q) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + 1'b1;
					end else begin
						out_col_q <= out_col_q + 1'b1;
					end
				end
			end
		end
	end

	// Window sweep: one tap per cycle, accumulated in the cycle after its read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_ok_s1 <= 1'b0;
		end else begin
			tap_ok_s1 <= (state_q == bmf_pkg::ST_SWEEP) && tap_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == bmf_pkg::ST_DECIDE) begin
			ti_q       <= '0;
			tj_q       <= '0;
			row_base_q <= out_cnt_q[AW-1:0] - hhw_q[AW-1:0];
			sum_q      <= '0;
		end else begin
			if (state_q == bmf_pkg::ST_SWEEP) begin
				if (row_end) begin
					tj_q       <= '0;
					ti_q       <= ti_q + 1'b1;
					row_base_q <= row_base_q + AW'(fr_w_q);
				end else begin
					tj_q <= tj_q + 1'b1;
				end
			end
			if (tap_ok_s1) sum_q <= sum_q + SW'(rd_data);
		end
	end

	bmf_store #(
		.AW(AW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (in_cnt_q[AW-1:0]),
		.wr_data (pix_q),
		.rd_en   ((state_q == bmf_pkg::ST_SWEEP) && tap_ok),
		.rd_addr (tap_addr),
		.rd_data (rd_data)
	);

	bmf_div #(
		.DW(DW),
		.VW(VW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_ctl.start),
		.dividend (dividend),
		.divisor  (VW'({area_q, 1'b0})),
		.done     (div_ctl.done),
		.quotient (quotient)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == bmf_pkg::ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == bmf_pkg::ST_OUT && out_free) begin
			pixel_out_q  <= quotient[7:0];
			frame_last_q <= frame_end;
		end
	end

	assign out_valid  = out_valid_q;
	assign pixel_out  = pixel_out_q;
	assign frame_last = frame_last_q;

endmodule
`default_nettype wire
